FILE: design/pcpm_pkg.sv
// ----------------------------------------------------------------------------
// pcpm_pkg
// Shared types and constants for the pseudo-colour palette mapper: colour
// map codes, register indices, wavelength band limits and the reciprocal
// constants used by the false colour channel divider.
// ----------------------------------------------------------------------------
package pcpm_pkg;

  typedef enum logic [2:0] {
    MODE_GREY     = 3'd0,
    MODE_OVERLOAD = 3'd1,
    MODE_TERNARY  = 3'd2,
    MODE_PILEUP   = 3'd3,
    MODE_RAINBOW  = 3'd4,
    MODE_REVERSE  = 3'd5,
    MODE_TEMP     = 3'd6,
    MODE_FALSE    = 3'd7
  } map_mode_t;

  typedef enum logic [2:0] {
    REG_MAP_MODE   = 3'd0,
    REG_BACKGROUND = 3'd1,
    REG_FIRST      = 3'd2,
    REG_SECOND     = 3'd3,
    REG_THIRD      = 3'd4,
    REG_MARKS      = 3'd5,
    REG_BANDS      = 3'd6,
    REG_WAVELENGTH = 3'd7
  } cfg_reg_t;

  // Channel of a false colour result that still has to be divided.
  typedef enum logic [1:0] {
    FC_NONE  = 2'd0,
    FC_RED   = 2'd1,
    FC_GREEN = 2'd2,
    FC_BLUE  = 2'd3
  } fc_chan_t;

  // Odd part of the band width; the power of two is shifted off earlier.
  typedef enum logic [2:0] {
    DIV_BY_15 = 3'd0,
    DIV_BY_25 = 3'd1,
    DIV_BY_5  = 3'd2,
    DIV_BY_35 = 3'd3,
    DIV_BY_65 = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int unsigned RATIO_W = 15;

  typedef struct packed {
    rgb_t                 base;
    fc_chan_t             chan;
    div_sel_t             div;
    logic [RATIO_W-1:0]   ratio;
  } mid_t;

  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned MARKS_W    = 16;
  localparam int unsigned BANDS_W    = 24;
  localparam int unsigned WAVE_W     = 14;

  localparam logic [7:0] OVL_GREEN_START = 8'd245;
  localparam logic [7:0] OVL_RED_START   = 8'd250;
  localparam logic [7:0] RB_FIRST_BREAK  = 8'(256 / 3);
  localparam logic [7:0] RB_SECOND_BREAK = 8'(2 * (256 / 3));

  localparam rgb_t RGB_RED   = 24'hFF0000;
  localparam rgb_t RGB_GREEN = 24'h00FF00;
  localparam rgb_t RGB_BLUE  = 24'h0000FF;
  localparam rgb_t RGB_BLACK = 24'h000000;
  localparam rgb_t RGB_WHITE = 24'hFFFFFF;

  // Wavelength limits in sixteenths of a nanometre.
  localparam logic [WAVE_W-1:0] WL_380 = WAVE_W'(380 * 16);
  localparam logic [WAVE_W-1:0] WL_440 = WAVE_W'(440 * 16);
  localparam logic [WAVE_W-1:0] WL_490 = WAVE_W'(490 * 16);
  localparam logic [WAVE_W-1:0] WL_510 = WAVE_W'(510 * 16);
  localparam logic [WAVE_W-1:0] WL_580 = WAVE_W'(580 * 16);
  localparam logic [WAVE_W-1:0] WL_645 = WAVE_W'(645 * 16);
  localparam logic [WAVE_W-1:0] WL_780 = WAVE_W'(780 * 16);

  // floor(t / m) = (t * ceil(2^S / m)) >> S holds for t < 2^15 and m < 2^7.
  localparam int unsigned RECIP_SHIFT = 22;
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(((2 ** RECIP_SHIFT) + 14) / 15);
  localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(((2 ** RECIP_SHIFT) + 24) / 25);
  localparam logic [RECIP_W-1:0] RECIP_5  = RECIP_W'(((2 ** RECIP_SHIFT) + 4) / 5);
  localparam logic [RECIP_W-1:0] RECIP_35 = RECIP_W'(((2 ** RECIP_SHIFT) + 34) / 35);
  localparam logic [RECIP_W-1:0] RECIP_65 = RECIP_W'(((2 ** RECIP_SHIFT) + 64) / 65);

endpackage

FILE: design/pseudo_colour_palette_mapper.sv
// ----------------------------------------------------------------------------
// pseudo_colour_palette_mapper
// Maps an 8-bit palette index to red, green and blue levels of the colour
// map selected by the configuration registers.
// ----------------------------------------------------------------------------
// The mapper takes one index per clock while the output is not stalled. The
// path holds an input register, a register after the map logic and the false
// colour product, and the output register after the reciprocal divider. The
// two multipliers (weight times index, then the reciprocal of the band width)
// set the stage split. Ready follows the output side, so a stalled output
// holds at most three items in flight.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata in a single cycle and should only change while no transfer is
// in flight.
module pseudo_colour_palette_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_palette_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_red_level,
  output logic [7:0]                       out_green_level,
  output logic [7:0]                       out_blue_level,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [pcpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pcpm_pkg::*;

  map_mode_t          map_mode_r;
  logic [RGB_W-1:0]   background_r, first_r, second_r, third_r;
  logic [MARKS_W-1:0] marks_r;
  logic [BANDS_W-1:0] bands_r;
  logic [WAVE_W-1:0]  wavelength_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_index_r;
  logic       s2_valid_r, s2_valid_nxt;
  mid_t       s2_mid_r, s2_mid_nxt;
  logic       out_valid_r, out_valid_nxt;
  rgb_t       out_rgb_r, out_rgb_nxt;

  logic out_advance, s2_ready, s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r   <= MODE_GREY;
      background_r <= '0;
      first_r      <= '0;
      second_r     <= '0;
      third_r      <= '0;
      marks_r      <= '0;
      bands_r      <= '0;
      wavelength_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAP_MODE:   map_mode_r   <= map_mode_t'(cfg_wdata[2:0]);
        REG_BACKGROUND: background_r <= cfg_wdata[RGB_W-1:0];
        REG_FIRST:      first_r      <= cfg_wdata[RGB_W-1:0];
        REG_SECOND:     second_r     <= cfg_wdata[RGB_W-1:0];
        REG_THIRD:      third_r      <= cfg_wdata[RGB_W-1:0];
        REG_MARKS:      marks_r      <= cfg_wdata[MARKS_W-1:0];
        REG_BANDS:      bands_r      <= cfg_wdata[BANDS_W-1:0];
        REG_WAVELENGTH: wavelength_r <= cfg_wdata[WAVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage moves on when the stage after it is empty or moving too.
  assign out_advance = !out_valid_r || out_ready;
  assign s2_ready    = !s2_valid_r || out_advance;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ready    = s1_ready;

  assign s1_valid_nxt  = s1_ready ? in_valid : s1_valid_r;
  assign s2_valid_nxt  = s2_ready ? s1_valid_r : s2_valid_r;
  assign out_valid_nxt = out_advance ? s2_valid_r : out_valid_r;

  pcpm_front u_front (
    .index_i      (s1_index_r),
    .map_mode_i   (map_mode_r),
    .background_i (background_r),
    .first_i      (first_r),
    .second_i     (second_r),
    .third_i      (third_r),
    .marks_i      (marks_r),
    .bands_i      (bands_r),
    .wavelength_i (wavelength_r),
    .mid_o        (s2_mid_nxt)
  );

  pcpm_fcdiv u_fcdiv (
    .mid_i (s2_mid_r),
    .rgb_o (out_rgb_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_index_r <= in_palette_index;
    end
    if (s2_ready) begin
      s2_mid_r <= s2_mid_nxt;
    end
    if (out_advance) begin
      out_rgb_r <= out_rgb_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = out_rgb_r.red;
  assign out_green_level = out_rgb_r.green;
  assign out_blue_level  = out_rgb_r.blue;

`ifndef SYNTHESIS
  a_in_lands_in_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_valid_r)
    else $error("input transfer did not reach the first stage");

  a_s2_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_advance |=> s2_valid_r && $stable(s2_mid_r))
    else $error("middle stage changed while the output was stalled");

  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r))
    else $error("output became valid without a middle stage item");

  a_plain_colour_passes: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && out_advance && s2_mid_r.chan == FC_NONE |=>
      out_rgb_r == $past(s2_mid_r.base))
    else $error("undivided colour was altered by the divider stage");
`endif

endmodule

FILE: design/pcpm_front.sv
// ----------------------------------------------------------------------------
// pcpm_front
// First pass of the mapper: evaluates every colour map for one index and,
// for false colour, forms the scaled weight product that the divider stage
// finishes.
// ----------------------------------------------------------------------------
module pcpm_front (
  input  logic [7:0]                      index_i,
  input  pcpm_pkg::map_mode_t             map_mode_i,
  input  logic [pcpm_pkg::RGB_W-1:0]      background_i,
  input  logic [pcpm_pkg::RGB_W-1:0]      first_i,
  input  logic [pcpm_pkg::RGB_W-1:0]      second_i,
  input  logic [pcpm_pkg::RGB_W-1:0]      third_i,
  input  logic [pcpm_pkg::MARKS_W-1:0]    marks_i,
  input  logic [pcpm_pkg::BANDS_W-1:0]    bands_i,
  input  logic [pcpm_pkg::WAVE_W-1:0]     wavelength_i,
  output pcpm_pkg::mid_t                  mid_o
);
  import pcpm_pkg::*;

  function automatic rgb_t rainbow(input logic [7:0] k);
    logic [7:0] d;
    logic [8:0] d3;
    rgb_t       c;
    if (k < RB_FIRST_BREAK) begin
      d = k;
    end else if (k < RB_SECOND_BREAK) begin
      d = k - RB_FIRST_BREAK;
    end else begin
      d = k - RB_SECOND_BREAK;
    end
    d3 = {d, 1'b0} + {1'b0, d};
    if (k == 8'd0) begin
      c = RGB_BLACK;
    end else if (k == 8'hFF) begin
      c = RGB_WHITE;
    end else if (k < RB_FIRST_BREAK) begin
      c = '{red: 8'd0, green: d3[7:0], blue: 8'hFF};
    end else if (k < RB_SECOND_BREAK) begin
      c = '{red: d3[7:0], green: 8'hFF, blue: 8'hFF - d3[7:0]};
    end else begin
      c = '{red: 8'hFF, green: 8'hFF - d3[7:0], blue: 8'd0};
    end
    return c;
  endfunction

  rgb_t              grey;
  rgb_t              overload_c;
  rgb_t              ternary_c;
  rgb_t              pileup_c;
  rgb_t              temp_c;
  rgb_t              band1, band2, band3;
  logic signed [10:0] lim_a, lim_b, lim_c, k_s;
  logic [14:0]       temp_g_prod;
  logic [13:0]       temp_b_prod;
  rgb_t              fc_base;
  fc_chan_t          fc_chan;
  div_sel_t          fc_div;
  logic [10:0]       fc_weight;
  logic [18:0]       fc_prod;
  logic [18:0]       fc_shifted;

  assign grey = '{red: index_i, green: index_i, blue: index_i};

  always_comb begin
    if (index_i < OVL_GREEN_START) begin
      overload_c = grey;
    end else if (index_i < OVL_RED_START) begin
      overload_c = RGB_GREEN;
    end else begin
      overload_c = RGB_RED;
    end
  end

  // The second mark takes priority when both marks name the same index.
  always_comb begin
    if (index_i == marks_i[15:8]) begin
      ternary_c = rgb_t'(second_i);
    end else if (index_i == marks_i[7:0]) begin
      ternary_c = rgb_t'(first_i);
    end else begin
      ternary_c = rgb_t'(background_i);
    end
  end

  // Band limits may go negative; the parts below index zero never match.
  always_comb begin
    if (first_i == '0 && second_i == '0 && third_i == '0) begin
      band1 = RGB_RED;
      band2 = RGB_GREEN;
      band3 = RGB_BLUE;
    end else begin
      band1 = rgb_t'(first_i);
      band2 = rgb_t'(second_i);
      band3 = rgb_t'(third_i);
    end
    lim_a = 11'sd256 - $signed({3'b0, bands_i[7:0]});
    lim_b = lim_a - $signed({3'b0, bands_i[15:8]});
    lim_c = lim_b - $signed({3'b0, bands_i[23:16]});
    k_s   = $signed({3'b0, index_i});
    if (k_s >= lim_a) begin
      pileup_c = band1;
    end else if (k_s >= lim_b) begin
      pileup_c = band2;
    end else if (k_s >= lim_c) begin
      pileup_c = band3;
    end else begin
      pileup_c = grey;
    end
  end

  // x * 255 is formed as x * 256 - x; the divisions are plain shifts.
  always_comb begin
    temp_g_prod = {index_i[6:0], 8'd0} - {8'd0, index_i[6:0]};
    temp_b_prod = {index_i[5:0], 8'd0} - {8'd0, index_i[5:0]};
    temp_c.red   = index_i;
    temp_c.green = index_i[7] ? temp_g_prod[14:7] : 8'd0;
    temp_c.blue  = (index_i[7:6] == 2'b11) ? temp_b_prod[13:6] : 8'd0;
  end

  always_comb begin
    fc_base   = grey;
    fc_chan   = FC_NONE;
    fc_div    = DIV_BY_15;
    fc_weight = '0;
    if (wavelength_i >= WL_380 && wavelength_i < WL_440) begin
      fc_base   = '{red: 8'd0, green: 8'd0, blue: index_i};
      fc_chan   = FC_RED;
      fc_div    = DIV_BY_15;
      fc_weight = 11'(WL_440 - wavelength_i);
    end else if (wavelength_i >= WL_440 && wavelength_i < WL_490) begin
      fc_base   = '{red: 8'd0, green: 8'd0, blue: index_i};
      fc_chan   = FC_GREEN;
      fc_div    = DIV_BY_25;
      fc_weight = 11'(wavelength_i - WL_440);
    end else if (wavelength_i >= WL_490 && wavelength_i < WL_510) begin
      fc_base   = '{red: 8'd0, green: index_i, blue: 8'd0};
      fc_chan   = FC_BLUE;
      fc_div    = DIV_BY_5;
      fc_weight = 11'(WL_510 - wavelength_i);
    end else if (wavelength_i >= WL_510 && wavelength_i < WL_580) begin
      fc_base   = '{red: 8'd0, green: index_i, blue: 8'd0};
      fc_chan   = FC_RED;
      fc_div    = DIV_BY_35;
      fc_weight = 11'(wavelength_i - WL_510);
    end else if (wavelength_i >= WL_580 && wavelength_i < WL_645) begin
      fc_base   = '{red: index_i, green: 8'd0, blue: 8'd0};
      fc_chan   = FC_GREEN;
      fc_div    = DIV_BY_65;
      fc_weight = 11'(WL_645 - wavelength_i);
    end else if (wavelength_i >= WL_645 && wavelength_i < WL_780) begin
      fc_base   = '{red: index_i, green: 8'd0, blue: 8'd0};
    end
  end

  // The power-of-two part of each band width is removed here.
  always_comb begin
    fc_prod = {8'd0, fc_weight} * {11'd0, index_i};
    case (fc_div)
      DIV_BY_15: fc_shifted = fc_prod >> 6;
      DIV_BY_25: fc_shifted = fc_prod >> 5;
      DIV_BY_5:  fc_shifted = fc_prod >> 6;
      DIV_BY_35: fc_shifted = fc_prod >> 5;
      DIV_BY_65: fc_shifted = fc_prod >> 4;
      default:   fc_shifted = fc_prod;
    endcase
  end

  always_comb begin
    mid_o.chan  = FC_NONE;
    mid_o.div   = fc_div;
    mid_o.ratio = fc_shifted[RATIO_W-1:0];
    case (map_mode_i)
      MODE_GREY:     mid_o.base = grey;
      MODE_OVERLOAD: mid_o.base = overload_c;
      MODE_TERNARY:  mid_o.base = ternary_c;
      MODE_PILEUP:   mid_o.base = pileup_c;
      MODE_RAINBOW:  mid_o.base = rainbow(index_i);
      MODE_REVERSE:  mid_o.base = rainbow(~index_i);
      MODE_TEMP:     mid_o.base = temp_c;
      MODE_FALSE: begin
        mid_o.base = fc_base;
        mid_o.chan = fc_chan;
      end
      default:       mid_o.base = grey;
    endcase
  end

endmodule

FILE: design/pcpm_fcdiv.sv
// ----------------------------------------------------------------------------
// pcpm_fcdiv
// Second pass of the mapper: divides the false colour product by the odd
// part of the band width with a reciprocal multiply and places the quotient
// in its channel.
// ----------------------------------------------------------------------------
module pcpm_fcdiv (
  input  pcpm_pkg::mid_t  mid_i,
  output pcpm_pkg::rgb_t  rgb_o
);
  import pcpm_pkg::*;

  localparam int unsigned PROD_W = RATIO_W + RECIP_W;

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [7:0]         quo;

  always_comb begin
    case (mid_i.div)
      DIV_BY_15: recip = RECIP_15;
      DIV_BY_25: recip = RECIP_25;
      DIV_BY_5:  recip = RECIP_5;
      DIV_BY_35: recip = RECIP_35;
      DIV_BY_65: recip = RECIP_65;
      default:   recip = RECIP_15;
    endcase
  end

  assign prod = {{RECIP_W{1'b0}}, mid_i.ratio} * {{RATIO_W{1'b0}}, recip};
  assign quo  = prod[RECIP_SHIFT +: 8];

  always_comb begin
    rgb_o = mid_i.base;
    case (mid_i.chan)
      FC_NONE:  rgb_o = mid_i.base;
      FC_RED:   rgb_o.red   = quo;
      FC_GREEN: rgb_o.green = quo;
      FC_BLUE:  rgb_o.blue  = quo;
      default:  rgb_o = mid_i.base;
    endcase
  end

endmodule
